// ===== rtl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types and codes for the positional ordered list: command and status
// codes, controller states and the command/status bundles between modules.
// ----------------------------------------------------------------------------
package pol_pkg;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_POS  = 3'd2,
    CMD_DEL_HEAD = 3'd3,
    CMD_DEL_TAIL = 3'd4,
    CMD_DEL_POS  = 3'd5,
    CMD_READ     = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;     // accept beat: apply command, load its first result
    logic rd_next;  // load next entry of a read-all sequence
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic rd_multi; // command is read-all and the list holds more than one entry
    logic rd_last;  // next read entry is the tail
  } stat_t;

endpackage

// ===== rtl/positional_ordered_list.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list of signed words with insert, delete and read-all.
// ----------------------------------------------------------------------------
// Result: a result beat is registered and shows in the cycle after its command beat is accepted.
// Insert and delete are applied at once by the parallel cell shift; no-op changes nothing.
// Read-all gives one beat per entry (a single beat when empty), later beats from the read pointer.
// Reset clears the entry count and the output valid; cell contents are not reset.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    command_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic [7:0]                    position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic signed [VALUE_WIDTH-1:0] entry_o,
  output logic [$clog2(DEPTH+1)-1:0]    length_o,
  output logic                          last_o
);

  pol_pkg::ctrl_t ctrl;
  pol_pkg::stat_t stat;

  pol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  pol_dpath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .command_i  (command_i),
    .value_i    (value_i),
    .position_i (position_i),
    .status_o   (status_o),
    .entry_o    (entry_o),
    .length_o   (length_o),
    .last_o     (last_o)
  );

endmodule

// ===== rtl/pol_ctrl.sv =====
// ----------------------------------------------------------------------------
// pol_ctrl
// Controller: accepts command beats, sequences read-all beats and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module pol_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  pol_pkg::stat_t stat_i,
  output pol_pkg::ctrl_t ctrl_o
);

  pol_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    ctrl_o.exec    = 1'b0;
    ctrl_o.rd_next = 1'b0;
    in_stall_o     = 1'b1;
    case (state_q)
      pol_pkg::S_IDLE: begin
        in_stall_o  = !slot_free;
        ctrl_o.exec = in_valid_i && slot_free;
        if (ctrl_o.exec && stat_i.rd_multi) begin
          state_d = pol_pkg::S_READ;
        end
      end
      pol_pkg::S_READ: begin
        ctrl_o.rd_next = slot_free;
        if (slot_free && stat_i.rd_last) begin
          state_d = pol_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pol_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.exec || ctrl_o.rd_next) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pol_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/pol_dpath.sv =====
// ----------------------------------------------------------------------------
// pol_dpath
// Datapath: cell array with parallel shift for insert and delete, entry
// count, read pointer and the output result register.
// ----------------------------------------------------------------------------
module pol_dpath #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int LEN_W       = $clog2(DEPTH + 1),
  parameter int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pol_pkg::ctrl_t                ctrl_i,
  output pol_pkg::stat_t                stat_o,
  input  logic [2:0]                    command_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic [7:0]                    position_i,
  output logic [1:0]                    status_o,
  output logic signed [VALUE_WIDTH-1:0] entry_o,
  output logic [LEN_W-1:0]              length_o,
  output logic                          last_o
);

  logic [VALUE_WIDTH-1:0] cells_q [DEPTH];
  logic [VALUE_WIDTH-1:0] cells_d [DEPTH];
  logic [VALUE_WIDTH-1:0] up      [DEPTH];
  logic [VALUE_WIDTH-1:0] dn      [DEPTH];
  logic [LEN_W-1:0]       count_q, count_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  pol_pkg::status_e       status_q, status_d;
  logic [VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                   last_q, last_d;

  logic [7:0] cnt8, ins_pos, ins_idx, del_idx;
  logic       full, empty, badpos;

  // shifted copies of the cell array
  always_comb begin
    up[0]       = cells_q[0];
    dn[DEPTH-1] = cells_q[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) begin
      up[i]   = cells_q[i-1];
      dn[i-1] = cells_q[i];
    end
  end

  always_comb begin
    cnt8    = 8'(count_q);
    full    = (count_q == LEN_W'(DEPTH));
    empty   = (count_q == '0);
    badpos  = (position_i == 8'd0) || (position_i > cnt8);
    ins_pos = (position_i == 8'd0) ? 8'd1 : position_i;
    if (ins_pos > cnt8 + 8'd1) begin
      ins_pos = cnt8 + 8'd1;
    end
    case (command_i)
      pol_pkg::CMD_INS_TAIL: ins_idx = cnt8;
      pol_pkg::CMD_INS_POS:  ins_idx = ins_pos - 8'd1;
      default:               ins_idx = 8'd0;
    endcase
    case (command_i)
      pol_pkg::CMD_DEL_TAIL: del_idx = cnt8 - 8'd1;
      pol_pkg::CMD_DEL_POS:  del_idx = position_i - 8'd1;
      default:               del_idx = 8'd0;
    endcase
  end

  assign stat_o.rd_multi = (command_i == pol_pkg::CMD_READ) && (count_q > LEN_W'(1));
  assign stat_o.rd_last  = (LEN_W'(rd_idx_q) + LEN_W'(1)) == count_q;

  always_comb begin
    cells_d  = cells_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    status_d = status_q;
    entry_d  = entry_q;
    last_d   = last_q;
    if (ctrl_i.exec) begin
      status_d = pol_pkg::ST_OK;
      entry_d  = '0;
      last_d   = 1'b1;
      case (command_i)
        pol_pkg::CMD_INS_HEAD, pol_pkg::CMD_INS_TAIL, pol_pkg::CMD_INS_POS: begin
          if (full) begin
            status_d = pol_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (8'(i) == ins_idx) begin
                cells_d[i] = value_i;
              end else if (8'(i) > ins_idx) begin
                cells_d[i] = up[i];
              end
            end
            count_d = count_q + LEN_W'(1);
          end
        end
        pol_pkg::CMD_DEL_HEAD, pol_pkg::CMD_DEL_TAIL, pol_pkg::CMD_DEL_POS: begin
          if (empty) begin
            status_d = pol_pkg::ST_EMPTY;
          end else if ((command_i == pol_pkg::CMD_DEL_POS) && badpos) begin
            status_d = pol_pkg::ST_BADPOS;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (8'(i) >= del_idx) begin
                cells_d[i] = dn[i];
              end
            end
            count_d = count_q - LEN_W'(1);
          end
        end
        pol_pkg::CMD_READ: begin
          if (empty) begin
            status_d = pol_pkg::ST_EMPTY;
          end else begin
            entry_d  = cells_q[0];
            last_d   = (count_q == LEN_W'(1));
            rd_idx_d = IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (ctrl_i.rd_next) begin
      entry_d  = cells_q[rd_idx_q];
      last_d   = stat_o.rd_last;
      rd_idx_d = rd_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
    end else begin
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q  <= cells_d;
    status_q <= status_d;
    entry_q  <= entry_d;
    last_q   <= last_d;
  end

  assign status_o = status_q;
  assign entry_o  = entry_q;
  assign length_o = count_q;
  assign last_o   = last_q;

endmodule

// ===== rtl/pol_checker.sv =====
// ----------------------------------------------------------------------------
// pol_checker
// Port-level checks for the positional ordered list, bound to the top level.
// ----------------------------------------------------------------------------
module pol_checker #(
  parameter int DEPTH = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 status_o,
  input logic [$clog2(DEPTH+1)-1:0] length_o,
  input logic                       last_o
);

  localparam int LEN_W = $clog2(DEPTH + 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == pol_pkg::ST_OK)
    else $error("non-final read beat without ok status");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_o <= LEN_W'(DEPTH))
    else $error("length above depth");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("command accepted during read-all sequence");

endmodule

bind positional_ordered_list pol_checker #(
  .DEPTH (DEPTH)
) u_pol_checker (.*);
